>>> rtl/rational_normalize_macros.svh
// assertion macros shared by the rational_normalize checker
// no dependencies; the user must provide clk and rst in scope
`ifndef RATIONAL_NORMALIZE_MACROS_SVH
`define RATIONAL_NORMALIZE_MACROS_SVH

// same-cycle implication, checked outside reset
`define RN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_normalize check failed");

// next-cycle implication, checked outside reset
`define RN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_normalize check failed");

`endif

>>> rtl/ratnorm_pkg.sv
// types and constants for the rational_normalize block
// no dependencies
package ratnorm_pkg;

  localparam int DW = 32;
  localparam int KW = 5;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERODEN  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic scale;
    logic div_step;
    logic finish;
  } ratnorm_cmd_t;

  typedef struct packed {
    logic special;
    logic gcd_done;
    logic div_done;
  } ratnorm_sts_t;

endpackage

>>> rtl/ratnorm_ctrl.sv
// controller state machine for rational_normalize
// depends on ratnorm_pkg
module ratnorm_ctrl
  import ratnorm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  ratnorm_sts_t sts,
  output ratnorm_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_GCD;
      end
      ST_GCD: begin
        if (sts.special) state_next = ST_FINISH;
        else if (sts.gcd_done) state_next = ST_SCALE;
      end
      ST_SCALE:  state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_GCD:    cmd.gcd_step = !sts.special && !sts.gcd_done;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_FINISH: cmd.finish   = out_free;
      default:   cmd          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/ratnorm_dp.sv
// datapath for rational_normalize: binary gcd, two-lane restoring divider, output register
// depends on ratnorm_pkg
module ratnorm_dp
  import ratnorm_pkg::*;
(
  input  logic                 clk,
  input  logic signed [DW-1:0] numer_in,
  input  logic signed [DW-1:0] denom_in,
  input  ratnorm_cmd_t         cmd,
  output ratnorm_sts_t         sts,
  output logic signed [DW-1:0] numer_out,
  output logic [DW-2:0]        denom_out,
  output logic [1:0]           status
);

  logic [DW-1:0] an, ad, x, y, g, rem_n, rem_d, q_n, q_d;
  logic [KW-1:0] k, cnt;
  logic          neg, dz, nz;

  logic [DW-1:0] n_u, d_u, neg_q;
  logic [DW:0]   sh_n, sh_d, g_ext;
  logic          ge_n, ge_d;

  assign n_u   = $unsigned(numer_in);
  assign d_u   = $unsigned(denom_in);
  assign g_ext = {1'b0, g};
  assign sh_n  = {rem_n, q_n[DW-1]};
  assign sh_d  = {rem_d, q_d[DW-1]};
  assign ge_n  = sh_n >= g_ext;
  assign ge_d  = sh_d >= g_ext;
  assign neg_q = {DW{1'b0}} - q_n;

  assign sts.special  = dz || nz;
  assign sts.gcd_done = x == y;
  assign sts.div_done = cnt == {KW{1'b1}};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an  <= n_u[DW-1] ? ({DW{1'b0}} - n_u) : n_u;
      ad  <= d_u[DW-1] ? ({DW{1'b0}} - d_u) : d_u;
      x   <= n_u[DW-1] ? ({DW{1'b0}} - n_u) : n_u;
      y   <= d_u[DW-1] ? ({DW{1'b0}} - d_u) : d_u;
      k   <= '0;
      neg <= n_u[DW-1] ^ d_u[DW-1];
      dz  <= d_u == '0;
      nz  <= n_u == '0;
    end

    // one binary gcd step: strip common twos, strip lone twos, or subtract odd values
    if (cmd.gcd_step) begin
      if (!x[0] && !y[0]) begin
        x <= x >> 1;
        y <= y >> 1;
        k <= KW'(k + 1'b1);
      end else if (!x[0]) begin
        x <= x >> 1;
      end else if (!y[0]) begin
        y <= y >> 1;
      end else if (x > y) begin
        x <= (x - y) >> 1;
      end else begin
        y <= (y - x) >> 1;
      end
    end

    if (cmd.scale) begin
      g     <= x << k;
      rem_n <= '0;
      rem_d <= '0;
      q_n   <= an;
      q_d   <= ad;
      cnt   <= '0;
    end

    if (cmd.div_step) begin
      rem_n <= ge_n ? DW'(sh_n - g_ext) : sh_n[DW-1:0];
      rem_d <= ge_d ? DW'(sh_d - g_ext) : sh_d[DW-1:0];
      q_n   <= {q_n[DW-2:0], ge_n};
      q_d   <= {q_d[DW-2:0], ge_d};
      cnt   <= KW'(cnt + 1'b1);
    end

    if (cmd.finish) begin
      if (dz) begin
        numer_out <= '0;
        denom_out <= '0;
        status    <= STATUS_ZERODEN;
      end else if (nz) begin
        numer_out <= '0;
        denom_out <= (DW-1)'(1);
        status    <= STATUS_OK;
      end else if (q_d[DW-1] || (!neg && q_n[DW-1])) begin
        numer_out <= '0;
        denom_out <= '0;
        status    <= STATUS_OVERFLOW;
      end else begin
        numer_out <= $signed(neg ? neg_q : q_n);
        denom_out <= q_d[DW-2:0];
        status    <= STATUS_OK;
      end
    end
  end

endmodule

>>> rtl/rational_normalize.sv
// rational_normalize: reduces a signed 32-bit fraction to lowest terms
// depends on ratnorm_pkg, ratnorm_ctrl, ratnorm_dp
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   input    | in_valid / in_stall  | numer_in, denom_in
//   output   | out_valid / out_stall| numer_out, denom_out, status
//
// one item in flight; a transfer in is taken only while the controller is idle
// each item runs load, binary gcd steps until done, a gcd done check, a scale,
//   the bit-serial divide and a finish; the binary gcd takes one step per cycle
// zero numerator or zero denominator skips the gcd steps, scale and divide
// the finished result sits in an output register, so the next transfer in can
//   start while that result is stalled; the finish step waits for the register
// synchronous active-high reset clears the controller state and output valid only
module rational_normalize
  import ratnorm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] numer_in,
  input  logic signed [DW-1:0] denom_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] numer_out,
  output logic [DW-2:0]        denom_out,
  output logic [1:0]           status
);

  // command and status between controller and datapath
  ratnorm_cmd_t cmd;
  ratnorm_sts_t sts;

  // sequencing: load, gcd loop, scale gcd, divide both magnitudes, write result
  ratnorm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // magnitudes, gcd registers, divider lanes and the output payload register
  ratnorm_dp u_dp (
    .clk       (clk),
    .numer_in  (numer_in),
    .denom_in  (denom_in),
    .cmd       (cmd),
    .sts       (sts),
    .numer_out (numer_out),
    .denom_out (denom_out),
    .status    (status)
  );

endmodule

>>> rtl/ratnorm_checker.sv
// port-level checks for rational_normalize, bound to the top level
// depends on ratnorm_pkg and rational_normalize_macros.svh
`include "rational_normalize_macros.svh"

module ratnorm_checker
  import ratnorm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [DW-1:0] numer_out,
  input logic [DW-2:0]        denom_out,
  input logic [1:0]           status
);

  // a held result stays offered
  `RN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // one item at a time: busy right after a transfer in
  `RN_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
  // error results carry zero fields
  `RN_ASSERT_NOW(a_err_zero, out_valid && status != STATUS_OK, numer_out == '0 && denom_out == '0)
  // good results have a positive denominator, and 0 comes as 0/1
  `RN_ASSERT_NOW(a_ok_den, out_valid && status == STATUS_OK, denom_out != '0)
  `RN_ASSERT_NOW(a_zero_num, out_valid && status == STATUS_OK && numer_out == '0,
                 denom_out == (DW-1)'(1))

endmodule

bind rational_normalize ratnorm_checker u_ratnorm_checker (.*);

>>> verif/tb_rational_normalize.sv
// self-checking testbench for rational_normalize: fraction reduction by gcd
// depends on ratnorm_pkg and the rational_normalize rtl, nothing else
module tb_rational_normalize
  import ratnorm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one reduced fraction as the block reports it
  typedef struct packed {
    logic signed [DW-1:0] numer;
    logic [DW-2:0]        denom;
    logic [1:0]           status;
  } fraction_t;

  // dut ports, with the inputs driven to known values from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [DW-1:0] numer_in = '0;
  logic signed [DW-1:0] denom_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] numer_out;
  logic [DW-2:0]        denom_out;
  logic [1:0]           status;

  // predicted fractions in transfer order, oldest at the front
  fraction_t   pending_results[$];
  fraction_t   oldest_result;

  // idling control: off during the back-to-back stretch
  bit          idle_on = 1'b1;
  int unsigned stall_burst = 0;

  int unsigned fractions_sent = 0;
  int unsigned mismatches = 0;
  int unsigned seen_reduced = 0;
  int unsigned seen_zero_den = 0;
  int unsigned seen_overflow = 0;

  rational_normalize dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .numer_in  (numer_in),
    .denom_in  (denom_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .numer_out (numer_out),
    .denom_out (denom_out),
    .status    (status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lowest-terms prediction: euclid on the magnitudes, sign moved to the numerator
  function automatic fraction_t reduce_fraction(input logic [DW-1:0] n,
                                                input logic [DW-1:0] d);
    fraction_t   r;
    logic [DW-1:0] mag_n, mag_d, x, y, g, quot_n, quot_d;
    logic        neg;
    r.numer  = '0;
    r.denom  = '0;
    r.status = STATUS_OK;
    if (d == '0) begin
      r.status = STATUS_ZERODEN;
    end else if (n == '0) begin
      // 0/d is always 0/1, sign of d dropped
      r.denom = (DW-1)'(1);
    end else begin
      // -2^31 wraps to 2^31 here, which the unsigned compare below catches
      mag_n = n[DW-1] ? -n : n;
      mag_d = d[DW-1] ? -d : d;
      x = mag_n;
      y = mag_d;
      while (x != '0 && y != '0) begin
        if (x > y) begin
          x = x % y;
        end else begin
          y = y % x;
        end
      end
      g = x + y;
      quot_n = mag_n / g;
      quot_d = mag_d / g;
      neg = n[DW-1] ^ d[DW-1];
      // denominator of 2^31, or a positive numerator of 2^31, does not fit
      if (quot_d[DW-1] || (!neg && quot_n[DW-1])) begin
        r.status = STATUS_OVERFLOW;
      end else begin
        r.numer = neg ? -quot_n : quot_n;
        r.denom = quot_d[DW-2:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log short when things go badly wrong, but count everything
    if (mismatches < 40) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // one input transfer; valid stays high from one fraction to the next
  // unless the sender decides to idle
  task automatic offer_fraction(input logic [DW-1:0] n, input logic [DW-1:0] d);
    int unsigned gap_len;
    if (idle_on && $urandom_range(0, 99) < 29) begin
      // mostly short gaps, now and then long enough to land mid-computation
      gap_len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 160) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    numer_in <= n;
    denom_in <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(reduce_fraction(n, d));
    fractions_sent++;
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // values on the corners of the 32-bit range, signed powers of two, or random ones
  function automatic logic [DW-1:0] pick_edge_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3:       return {1'b1, {(DW-1){1'b0}}};
      4:       return {1'b0, {(DW-1){1'b1}}};
      5:       return 1 << $urandom_range(0, DW-1);
      6:       return -(1 << $urandom_range(0, DW-1));
      default: return $urandom();
    endcase
  endfunction

  // receiver stalls: ~29% of cycles, with occasional long holds so the
  // finish step has to wait on a full output register
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst != 0) begin
      out_stall <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 99) < 29) begin
      out_stall <= 1'b1;
      if ($urandom_range(0, 49) == 0) begin
        stall_burst <= $urandom_range(10, 150);
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: each output transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d status %0d",
                                  numer_out, denom_out, status));
      end else begin
        oldest_result = pending_results.pop_front();
        if (numer_out !== oldest_result.numer) begin
          report_mismatch($sformatf("numer_out %0d, want %0d",
                                    numer_out, oldest_result.numer));
        end
        if (denom_out !== oldest_result.denom) begin
          report_mismatch($sformatf("denom_out %0d, want %0d",
                                    denom_out, oldest_result.denom));
        end
        if (status !== oldest_result.status) begin
          report_mismatch($sformatf("status %0d, want %0d",
                                    status, oldest_result.status));
        end
        case (oldest_result.status)
          STATUS_OK:      seen_reduced++;
          STATUS_ZERODEN: seen_zero_den++;
          default:        seen_overflow++;
        endcase
      end
    end
  end

  // corners of the range and every named special case
  task automatic test_special_cases();
    logic [DW-1:0] min_val, max_val;
    min_val = {1'b1, {(DW-1){1'b0}}};
    max_val = {1'b0, {(DW-1){1'b1}}};
    offer_fraction(0, 0);                   // zero denominator, zero numerator too
    offer_fraction(5, 0);                   // zero denominator
    offer_fraction(min_val, 0);
    offer_fraction(0, 5);                   // zero numerator gives 0/1
    offer_fraction(0, -7);                  // ... regardless of denominator sign
    offer_fraction(0, min_val);
    offer_fraction(min_val, -1);            // would be +2^31: overflow
    offer_fraction(min_val, -3);            // same, through the gcd path
    offer_fraction(3, min_val);             // odd over -2^31: overflow
    offer_fraction(-1, min_val);
    offer_fraction(max_val, min_val);
    offer_fraction(min_val, 1);             // -2^31 itself is fine
    offer_fraction(min_val, 3);
    offer_fraction(min_val, min_val);       // 1/1
    offer_fraction(2, min_val);             // even numerator reduces -2^31 away
    offer_fraction(32'h4000_0000, min_val); // -1/2
    offer_fraction(min_val, max_val);
    offer_fraction(max_val, max_val);
    offer_fraction(max_val, -1);
    offer_fraction(-1, -1);
    offer_fraction(1, 1);
    offer_fraction(6, -4);                  // sign moves to the numerator
    offer_fraction(-12, -18);
    offer_fraction(1836311903, 1134903170); // consecutive fibonacci: longest euclid
  endtask

  // full-range random values, every bit of both fields toggles
  task automatic test_random_full(input int unsigned count);
    repeat (count) begin
      offer_fraction($urandom(), $urandom());
    end
  endtask

  // shared factors so the reduction actually does something, with random signs
  // and the occasional -2^31 denominator
  task automatic test_common_factors(input int unsigned count);
    logic [DW-1:0] g, a, b, n, d;
    repeat (count) begin
      g = ($urandom_range(0, 3) == 0) ? (1 << $urandom_range(0, 20))
                                      : $urandom_range(1, 65535);
      a = $urandom() >> $urandom_range(8, 31);
      b = $urandom() >> $urandom_range(8, 31);
      n = a * g;
      d = b * g;
      if ($urandom_range(0, 1)) n = -n;
      if ($urandom_range(0, 1)) d = -d;
      if ($urandom_range(0, 15) == 0) d = {1'b1, {(DW-1){1'b0}}};
      offer_fraction(n, d);
    end
  endtask

  // corner values mixed with each other and with random ones
  task automatic test_edge_mix(input int unsigned count);
    repeat (count) begin
      offer_fraction(pick_edge_value(), pick_edge_value());
    end
  endtask

  // small signed values with no idling on either side
  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    repeat (count) begin
      offer_fraction($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
    end
    wait_for_drain();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_cases();
    wait_for_drain();
    test_random_full(300);
    wait_for_drain();
    test_common_factors(500);
    test_edge_mix(300);
    wait_for_drain();
    test_back_to_back(200);

    // settle: nothing pending, then room for a stray extra result
    wait_for_drain();
    repeat (300) @(posedge clk);

    $display("covered %0d fractions: %0d reduced, %0d zero denominator, %0d overflow",
             fractions_sent, seen_reduced, seen_zero_den, seen_overflow);
    $display("%0d mismatches, %0d results still pending", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_rational_normalize OK");
    end else begin
      $display("tb_rational_normalize NOT OK");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legitimate run
  initial begin
    #20_000_000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("tb_rational_normalize NOT OK");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ratnorm_pkg.sv
rtl/ratnorm_ctrl.sv
rtl/ratnorm_dp.sv
rtl/rational_normalize.sv
rtl/ratnorm_checker.sv
verif/tb_rational_normalize.sv
